// ----- rtl/pfra_pkg.sv -----
// ----------------------------------------------------------------------------
// pfra_pkg
// Shared types and constants for the page frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfra_pkg;

  localparam int ADDR_W   = 40;
  localparam int STAT_W   = 3;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 48;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 64;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] REG_MEMORY_BASE = 2'd0;
  localparam logic [1:0] REG_USER_LOW    = 2'd1;
  localparam logic [1:0] REG_MEMORY_TOP  = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_OOM    = 3'd1,
    ST_NOPAGE = 3'd2,
    ST_DOUBLE = 3'd3,
    ST_BELOW  = 3'd4
  } status_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic prep;
    logic load;
    logic scan;
    logic alloc_hit;
    logic oom;
    logic free_chk;
    logic free_upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_free;
    logic scan_hit;
    logic scan_empty;
    logic f_stop;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/page_frame_refcount_allocator.sv -----
// ----------------------------------------------------------------------------
// page_frame_refcount_allocator
// Physical page allocator with an 8-bit reference count per page.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake         Payload
// s_*       in   s_tvalid/s_tready tdata[39:0] address, tuser operation
// m_*       out  m_tvalid/m_tready tdata[39:0] page_address, [42:40] status
// apb       in   psel/penable      3 regs at 0x00, 0x08, 0x10, 64-bit data
//
// An allocation scans the counts one a cycle from the top page down; a release
// reads one count and decrements it unless zero, or stops when out of range.
// A clearing sweep after reset holds off requests only.
// A result waits in the output register while the next request runs; that
// request's result waits until the previous one has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_refcount_allocator #(
  parameter int PAGE_COUNT = 32768,
  parameter int PAGE_SHIFT = 12
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  input  wire  [pfra_pkg::S_DATA_W-1:0]   s_tdata,   // [39:0] address
  input  wire                             s_tuser,   // [0] operation
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [pfra_pkg::M_DATA_W-1:0]   m_tdata,   // [39:0] page_address, [42:40] status
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [pfra_pkg::CFG_AW-1:0]     paddr,
  input  wire  [pfra_pkg::CFG_DW-1:0]     pwdata,
  output logic [pfra_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready
);
  import pfra_pkg::*;

  logic [ADDR_W-1:0] memory_base, user_low, memory_top;
  logic              wr_en;
  cmd_t              cmd;
  sts_t              sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_base <= ADDR_W'(40'h00_8000_0000);
      user_low    <= ADDR_W'(40'h00_8040_0000);
      memory_top  <= ADDR_W'(40'h00_8800_0000);
    end else if (wr_en) begin
      unique case (paddr[4:3])
        REG_MEMORY_BASE: memory_base <= pwdata[ADDR_W-1:0];
        REG_USER_LOW:    user_low    <= pwdata[ADDR_W-1:0];
        REG_MEMORY_TOP:  memory_top  <= pwdata[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_MEMORY_BASE: prdata = CFG_DW'(memory_base);
      REG_USER_LOW:    prdata = CFG_DW'(user_low);
      REG_MEMORY_TOP:  prdata = CFG_DW'(memory_top);
      default:         prdata = '0;
    endcase
  end

  pfra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pfra_dp #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .memory_base (memory_base),
    .user_low    (user_low),
    .memory_top  (memory_top),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/pfra_dp.sv -----
// ----------------------------------------------------------------------------
// pfra_dp
// Datapath: count store, scan pointer, bound checks and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfra_dp #(
  parameter int PAGE_COUNT = 32768,
  parameter int PAGE_SHIFT = 12
) (
  input  wire                               clk,
  input  wire                               rst,
  input  pfra_pkg::cmd_t                    cmd,
  output pfra_pkg::sts_t                    sts,
  input  wire  [pfra_pkg::ADDR_W-1:0]       memory_base,
  input  wire  [pfra_pkg::ADDR_W-1:0]       user_low,
  input  wire  [pfra_pkg::ADDR_W-1:0]       memory_top,
  input  wire  [pfra_pkg::S_DATA_W-1:0]     s_tdata,
  input  wire                               s_tuser,
  input  wire                               m_tready,
  output logic                              m_tvalid,
  output logic [pfra_pkg::M_DATA_W-1:0]     m_tdata
);
  import pfra_pkg::*;

  localparam int IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int CW    = $clog2(PAGE_COUNT + 1);
  localparam int SW    = ADDR_W - PAGE_SHIFT;
  localparam int PAD_W = M_DATA_W - ADDR_W - STAT_W;

  logic [7:0]        mem [PAGE_COUNT];
  logic [7:0]        rdata;
  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [7:0]        wdata;

  logic              op_free;
  logic [ADDR_W-1:0] addr;
  logic [SW-1:0]     top_sh, low_sh, adr_sh;
  logic              f_below, f_beyond;
  logic [CW-1:0]     ptr, lowr;
  logic              pend_v;
  logic [IDX_W-1:0]  pend_idx;
  logic [ADDR_W-1:0] res_addr, out_addr;
  status_t           res_status, out_status;

  logic [ADDR_W:0]   top_sub, low_sub, adr_sub;
  logic              issue, adr_ovf;
  logic [IDX_W-1:0]  rd_idx, adr_idx;

  function automatic logic [CW-1:0] clamp_idx(input logic [SW-1:0] sh);
    if (sh >= SW'(PAGE_COUNT)) begin
      return CW'(PAGE_COUNT);
    end
    return CW'(sh);
  endfunction

  assign top_sub = {1'b0, memory_top} - {1'b0, memory_base};
  assign low_sub = {1'b0, user_low} - {1'b0, memory_base};
  assign adr_sub = {1'b0, addr} - {1'b0, memory_base};

  assign issue   = ptr > lowr;
  assign rd_idx  = IDX_W'(ptr - CW'(1));
  assign adr_ovf = adr_sh >= SW'(PAGE_COUNT);
  assign adr_idx = adr_sh[IDX_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = ptr[IDX_W-1:0];
    wdata = 8'd0;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.alloc_hit) begin
      we    = 1'b1;
      waddr = pend_idx;
      wdata = 8'd1;
    end else if (cmd.free_upd && rdata != 8'd0) begin
      we    = 1'b1;
      waddr = adr_idx;
      wdata = rdata - 8'd1;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = rd_idx;
    if (cmd.scan && issue) begin
      re = 1'b1;
    end else if (cmd.free_chk) begin
      re    = 1'b1;
      raddr = adr_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_free <= (s_tuser == OP_FREE);
      addr    <= s_tdata;
    end
    if (cmd.prep) begin
      top_sh   <= top_sub[ADDR_W] ? '0 : top_sub[ADDR_W-1:PAGE_SHIFT];
      low_sh   <= low_sub[ADDR_W] ? '0 : low_sub[ADDR_W-1:PAGE_SHIFT];
      adr_sh   <= adr_sub[ADDR_W-1:PAGE_SHIFT];
      f_below  <= addr < user_low;
      f_beyond <= (addr >= memory_top) || adr_sub[ADDR_W];
    end
    if (cmd.load) begin
      lowr <= clamp_idx(low_sh);
    end
    if (cmd.scan) begin
      pend_idx <= rd_idx;
    end
    if (cmd.alloc_hit) begin
      res_addr   <= memory_base + (ADDR_W'(pend_idx) << PAGE_SHIFT);
      res_status <= ST_OK;
    end else if (cmd.oom) begin
      res_addr   <= '0;
      res_status <= ST_OOM;
    end else if (cmd.free_chk) begin
      res_addr   <= '0;
      res_status <= f_below ? ST_BELOW : ST_NOPAGE;
    end else if (cmd.free_upd) begin
      res_addr   <= '0;
      res_status <= (rdata == 8'd0) ? ST_DOUBLE : ST_OK;
    end
    if (cmd.out_load) begin
      out_addr   <= res_addr;
      out_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      pend_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        ptr <= ptr + CW'(1);
      end else if (cmd.load) begin
        ptr <= clamp_idx(top_sh);
      end else if (cmd.scan && issue) begin
        ptr <= ptr - CW'(1);
      end
      if (cmd.load) begin
        pend_v <= 1'b0;
      end else if (cmd.scan) begin
        pend_v <= issue;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_status, out_addr};

  assign sts.clr_last   = (ptr == CW'(PAGE_COUNT - 1));
  assign sts.op_free    = op_free;
  assign sts.scan_hit   = pend_v && (rdata == 8'd0);
  assign sts.scan_empty = !pend_v && !issue;
  assign sts.f_stop     = f_below || f_beyond || adr_ovf;
  assign sts.out_busy   = m_tvalid && !m_tready;

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result register not loaded");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> (CW'(pend_idx) >= lowr))
    else $error("scan read below user bound");

  a_free_read: assert property (@(posedge clk) disable iff (rst)
    cmd.free_upd |-> $past(cmd.free_chk))
    else $error("release update without count read");

endmodule

`default_nettype wire

// ----- rtl/pfra_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfra_ctrl
// Controller: clearing sweep, request sequencing and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module pfra_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             s_tvalid,
  output logic            s_tready,
  output pfra_pkg::cmd_t  cmd,
  input  pfra_pkg::sts_t  sts
);
  import pfra_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_LOAD  = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_FCHK  = 8'b0010_0000,
    S_FRD   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = sts.op_free ? S_FCHK : S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit) begin
          cmd.alloc_hit = 1'b1;
          state_next    = S_OUT;
        end else if (sts.scan_empty) begin
          cmd.oom    = 1'b1;
          state_next = S_OUT;
        end
      end
      S_FCHK: begin
        cmd.free_chk = 1'b1;
        state_next   = sts.f_stop ? S_OUT : S_FRD;
      end
      S_FRD: begin
        cmd.free_upd = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_PREP))
    else $error("accepted request not started");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_busy)
    else $error("result overwritten before taken");

  a_scan_single: assert property (@(posedge clk) disable iff (rst)
    (cmd.alloc_hit || cmd.oom) |-> (state == S_SCAN) && !(cmd.alloc_hit && cmd.oom))
    else $error("scan outcome conflict");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the page frame allocator. Allocate and release
// requests go in over the stream input. A shadow copy of the count store and
// the address map predicts every result, and the checker compares each
// result with the oldest prediction. The directed tests cover the reset map,
// a small pool, the extreme and odd maps, and a long output stall. Random
// traffic then runs over random maps.
// ----------------------------------------------------------------------------
module testbench;
  import pfra_pkg::*;

  localparam int PAGE_COUNT  = 32768;
  localparam int PAGE_SHIFT  = 12;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    status_t           status;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;   // [39:0] address
  logic                s_tuser = 1'b0; // [0] operation
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;        // [39:0] page_address, [42:40] status
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  // shadow of the block's map and count store
  logic [ADDR_W-1:0] map_base     = 40'h00_8000_0000;
  logic [ADDR_W-1:0] map_user_low = 40'h00_8040_0000;
  logic [ADDR_W-1:0] map_top      = 40'h00_8800_0000;
  logic [7:0]        page_refs [PAGE_COUNT];

  outcome_t    awaited_outcomes[$];
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned status_seen [8];
  int unsigned maps_applied = 0;

  bit          tx_steady = 1'b0;
  int unsigned burst_left = 0;
  bit          rx_steady = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left = 0;
  logic [15:0] rx_pattern = '0;
  int unsigned rx_phase = 0;

  page_frame_refcount_allocator #(
    .PAGE_COUNT(PAGE_COUNT),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] rand_address();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // page number relative to the map base, zero at or below it
  function automatic logic [63:0] page_slot(input logic [ADDR_W-1:0] a);
    if (a <= map_base) return 64'd0;
    return 64'(a - map_base) >> PAGE_SHIFT;
  endfunction

  function automatic outcome_t allocator_outcome(input logic op, input logic [ADDR_W-1:0] a);
    outcome_t    r;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] idx;
    r.page_address = '0;
    r.status = ST_OOM;
    if (op == OP_ALLOC) begin
      hi = page_slot(map_top);
      lo = page_slot(map_user_low);
      if (hi > PAGE_COUNT) hi = PAGE_COUNT;
      for (idx = hi; idx > lo; idx--) begin
        if (page_refs[idx - 1] == 8'd0) begin
          page_refs[idx - 1] = 8'd1;
          r.page_address = map_base + ((idx - 1) << PAGE_SHIFT);
          r.status = ST_OK;
          break;
        end
      end
    end else if (a < map_user_low) begin
      r.status = ST_BELOW;
    end else if (a >= map_top || a < map_base) begin
      r.status = ST_NOPAGE;
    end else begin
      idx = 64'(a - map_base) >> PAGE_SHIFT;
      if (idx >= PAGE_COUNT) r.status = ST_NOPAGE;
      else if (page_refs[idx] == 8'd0) r.status = ST_DOUBLE;
      else begin
        page_refs[idx] = page_refs[idx] - 8'd1;
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    if (!tx_steady && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= addr;
    do @(posedge clk); while (!s_tready);
    awaited_outcomes.push_back(allocator_outcome(op, addr));
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [ADDR_W-1:0] value);
    logic [CFG_DW-1:0] word;
    word = {24'($urandom), value};
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      REG_MEMORY_BASE: map_base = value;
      REG_USER_LOW:    map_user_low = value;
      REG_MEMORY_TOP:  map_top = value;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_map(input logic [ADDR_W-1:0] base, low, top);
    write_register(REG_MEMORY_BASE, base);
    write_register(REG_USER_LOW, low);
    write_register(REG_MEMORY_TOP, top);
    maps_applied++;
  endtask

  // reset map: grant from the top, reuse, and every release outcome
  task automatic test_reset_map();
    tx_steady = 1'b1;
    rx_steady = 1'b0;
    repeat (3) send_request(OP_ALLOC, rand_address());
    send_request(OP_FREE, 40'h00_87FF_E000);
    send_request(OP_FREE, 40'h00_87FF_E800);
    send_request(OP_ALLOC, rand_address());
    send_request(OP_FREE, 40'h00_8000_0000);
    send_request(OP_FREE, 40'h00_803F_FFFF);
    send_request(OP_FREE, 40'h00_8040_0000);
    send_request(OP_FREE, 40'h00_8800_0000);
    send_request(OP_FREE, ADDR_MAX);
    send_request(OP_FREE, 40'h0);
    drain_results();
  endtask

  // six user pages: exhaust, out of memory, kernel page, edges of the map
  task automatic test_small_pool();
    logic [ADDR_W-1:0] base;
    base = 40'h10_0000_0000;
    tx_steady = 1'b0;
    rx_steady = 1'b1;
    apply_map(base, base + 40'h4000, base + 40'hA000);
    write_register(REG_SPARE, 40'hFF_FFFF_F000);
    repeat (7) send_request(OP_ALLOC, rand_address());
    send_request(OP_FREE, base + 40'h1000);
    send_request(OP_FREE, base + 40'hA000);
    send_request(OP_FREE, base + 40'h9FFF);
    send_request(OP_ALLOC, rand_address());
    send_request(OP_FREE, base + 40'h4000);
    send_request(OP_FREE, base + 40'h4000);
    drain_results();
  endtask

  // register extremes and maps with bounds out of order
  task automatic test_odd_maps();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    apply_map(40'h0, 40'h0, ADDR_MAX);
    send_request(OP_ALLOC, rand_address());
    send_request(OP_FREE, 40'h00_0800_0000);
    send_request(OP_FREE, 40'h0);
    send_request(OP_FREE, 40'h00_07FF_F123);
    drain_results();
    apply_map(40'h5000, 40'h1000, 40'h7000);
    repeat (3) send_request(OP_ALLOC, rand_address());
    send_request(OP_FREE, 40'h2000);
    drain_results();
    apply_map(ADDR_MAX, ADDR_MAX, ADDR_MAX);
    send_request(OP_ALLOC, rand_address());
    send_request(OP_FREE, ADDR_MAX);
    send_request(OP_FREE, 40'h0);
    drain_results();
    apply_map(ADDR_MAX, 40'h0, 40'h0);
    send_request(OP_ALLOC, rand_address());
    send_request(OP_FREE, 40'h123);
    drain_results();
  endtask

  // output held off while requests keep coming
  task automatic test_back_pressure();
    logic [ADDR_W-1:0] base;
    base = 40'h00_4000_0000;
    apply_map(base, base + 40'h2000, base + 40'h12000);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    hold_request = 1'b1;
    for (int k = 0; k < 12; k++) begin
      if (k < 8) send_request(OP_ALLOC, rand_address());
      else send_request(OP_FREE, base + 40'h12000 - 40'((k - 7) << PAGE_SHIFT));
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] low;
    logic [ADDR_W-1:0] top;
    logic [ADDR_W-1:0] addr;
    logic              op;
    int unsigned       pick;
    for (int round = 0; round < 3; round++) begin
      base = rand_address();
      base[11:0] = '0;
      if (&base[39:24]) base[39] = 1'b0;
      low = base + (40'($urandom_range(0, 6)) << PAGE_SHIFT);
      top = low + (40'($urandom_range(1, 24)) << PAGE_SHIFT);
      if ($urandom_range(0, 3) == 0 && base >= 40'h3000) low = base - 40'h3000;
      if ($urandom_range(0, 3) == 0) begin
        base[11:0] = 12'($urandom);
        low[11:0]  = 12'($urandom);
        top[11:0]  = 12'($urandom);
      end
      apply_map(base, low, top);
      tx_steady = (round == 1);
      rx_steady = (round == 1);
      repeat (20) begin
        pick = $urandom_range(0, 99);
        op = OP_FREE;
        if (pick < 45) begin
          op = OP_ALLOC;
          addr = rand_address();
        end else if (pick < 80) begin
          addr = low + 40'($urandom_range(0, 32'(top - low - 1)));
        end else if (pick < 92) begin
          addr = base - 40'h4000 + 40'($urandom_range(0, 32'(top - base) + 32'h8000));
        end else begin
          addr = rand_address();
        end
        send_request(op, addr);
      end
      drain_results();
    end
  endtask

  // receiver: random stall pattern, steady mode, or one long hold-off
  always @(negedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_steady) begin
      m_tready <= 1'b1;
    end else begin
      if (rx_phase == 0) rx_pattern = 16'($urandom | $urandom);
      m_tready <= rx_pattern[rx_phase];
      rx_phase = (rx_phase + 1) % 16;
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, got page_address %h status %0d",
                 $time, m_tdata[39:0], m_tdata[42:40]);
      end else begin
        want = awaited_outcomes.pop_front();
        checked++;
        status_seen[want.status]++;
        if (m_tdata[39:0] !== want.page_address) begin
          mismatches++;
          $display("%0t ns: page_address expected %h, got %h",
                   $time, want.page_address, m_tdata[39:0]);
        end
        if (m_tdata[42:40] !== want.status) begin
          mismatches++;
          $display("%0t ns: status expected %0d, got %0d", $time, want.status, m_tdata[42:40]);
        end
      end
    end
  end

  initial begin
    foreach (page_refs[i]) page_refs[i] = 8'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_map();
    test_small_pool();
    test_odd_maps();
    test_back_pressure();
    test_random_traffic();
    repeat (50) @(posedge clk);
    $display("Checked %0d results: %0d granted or released, %0d out of memory, %0d no such page, %0d double free, %0d below user region",
             checked, status_seen[ST_OK], status_seen[ST_OOM], status_seen[ST_NOPAGE],
             status_seen[ST_DOUBLE], status_seen[ST_BELOW]);
    $display("Covered %0d address maps, a %0d-cycle output hold-off, idle and steady phases",
             maps_applied, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", awaited_outcomes.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- page_frame_refcount_allocator.f -----
rtl/pfra_pkg.sv
rtl/pfra_dp.sv
rtl/pfra_ctrl.sv
rtl/page_frame_refcount_allocator.sv
verif/testbench.sv
